// ===== src/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int REQ_W   = 3;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 5;
    localparam int COUNT_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FIND       = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    localparam logic [FOUND_W-1:0] NO_INDEX = 5'h1F;

    // Walker operations
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] at;
        logic [CNT_W-1:0] cnt;
        logic [VAL_W-1:0] value;
    } sle_cmd_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] index;
    } sle_rsp_t;

endpackage

// ===== src/sle_walker.sv =====
`timescale 1ns / 1ps

module sle_walker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sle_pkg::sle_cmd_t cmd,
    output sle_pkg::sle_rsp_t rsp
);
    import sle_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] at_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             more_reg, more_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [VAL_W-1:0] rd_data_reg;

    logic [VAL_W-1:0] mem [CAPACITY];

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             hit;

    assign hit = (state_reg == S_WALK) && pend_reg && (op_reg == OP_FIND)
                 && (rd_data_reg == val_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg;
        rsp.done       = 1'b0;
        rsp.hit        = hit;
        rsp.index      = pend_addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pend_next = 1'b0;
                    case (cmd.op)
                        OP_OPEN:
                        begin
                            // append at the tail: nothing to move
                            if (CNT_W'(cmd.at) == cmd.cnt)
                            begin
                                more_next  = 1'b0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                cur_next   = IDX_W'(cmd.cnt - 1'b1);
                                last_next  = cmd.at;
                                more_next  = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        OP_CLOSE:
                        begin
                            cur_next   = IDX_W'(cmd.at + 1'b1);
                            last_next  = IDX_W'(cmd.cnt - 1'b1);
                            // dropping the tail entry moves nothing
                            more_next  = ((CNT_W'(cmd.at) + 1'b1) != cmd.cnt);
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            cur_next   = '0;
                            last_next  = IDX_W'(cmd.cnt - 1'b1);
                            more_next  = 1'b1;
                            state_next = S_WALK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // retire the beat read last cycle
                wr_en = pend_reg && (op_reg != OP_FIND);
                // issue the next read
                if (more_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    case (op_reg)
                        OP_OPEN:  pend_addr_next = IDX_W'(cur_reg + 1'b1);
                        OP_CLOSE: pend_addr_next = IDX_W'(cur_reg - 1'b1);
                        default:  pend_addr_next = cur_reg;
                    endcase
                    if (cur_reg == last_reg)
                        more_next = 1'b0;
                    else if (op_reg == OP_OPEN)
                        cur_next = IDX_W'(cur_reg - 1'b1);
                    else
                        cur_next = IDX_W'(cur_reg + 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (hit)
                begin
                    rsp.done   = 1'b1;
                    more_next  = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (!more_reg)
                begin
                    if (op_reg == OP_OPEN)
                        state_next = S_PLACE;
                    else
                    begin
                        rsp.done   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = at_reg;
                wr_data    = val_reg;
                rsp.done   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            op_reg  <= cmd.op;
            at_reg  <= cmd.at;
            val_reg <= cmd.value;
        end
        cur_reg       <= cur_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[cur_reg];
    end

endmodule

// ===== src/sequential_list_engine_core.sv =====
`timescale 1ns / 1ps
// A rejected request, an unused code or a find on an empty list answers in the cycle after
// its start beat; any other request runs on the walker, which shifts or compares the entries
// one by one through the registered store port and for a push or insert writes the value last.
// Throughput: one request at a time; busy drops in the cycle that carries its result beat.
// Reset clears the entry count and all control; stored entries keep no reset value.
// Results come out as one-cycle done beats; the receiver cannot stall them.
module sequential_list_engine_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [sle_pkg::REQ_W-1:0]     req_type,
    input  logic        [sle_pkg::POS_W-1:0]     position,
    input  logic signed [sle_pkg::VAL_W-1:0]     value,
    output logic                                 done,
    output logic        [sle_pkg::STAT_W-1:0]    status,
    output logic signed [sle_pkg::FOUND_W-1:0]   found_index,
    output logic        [sle_pkg::COUNT_W-1:0]   entry_count
);
    import sle_pkg::*;

    localparam int CMP_W = POS_W + CNT_W;

    // Control state
    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 done_reg, done_next;

    // Result beat payload
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic [COUNT_W-1:0]   entry_count_reg, entry_count_next;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 bad_pos;
    logic                 walk_start;
    sle_cmd_t             cmd;
    sle_rsp_t             rsp;

    assign accept   = start && !busy_reg;
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign bad_pos  = (CMP_W'(position) >= CMP_W'(count_reg));

    // Decode the request beat: check it against the count, then either answer
    // at once or hand a move/search to the walker and update the count up front.
    always_comb
    begin
        busy_next        = busy_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        found_next       = found_reg;
        entry_count_next = entry_count_reg;
        walk_start       = 1'b0;
        cmd.op           = OP_FIND;
        cmd.at           = '0;
        cmd.cnt          = count_reg;
        cmd.value        = value;

        if (accept)
        begin
            status_next      = ST_OK;
            found_next       = NO_INDEX;
            entry_count_next = COUNT_W'(count_reg);
            case (req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (is_full)
                        status_next = ST_FULL;
                    else
                    begin
                        walk_start = 1'b1;
                        cmd.op     = OP_OPEN;
                        cmd.at     = (req_type == REQ_PUSH_FRONT) ? '0 : IDX_W'(count_reg);
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK:
                begin
                    if (is_empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        walk_start = 1'b1;
                        cmd.op     = OP_CLOSE;
                        cmd.at     = (req_type == REQ_POP_FRONT) ? '0
                                     : IDX_W'(count_reg - 1'b1);
                        count_next = CNT_W'(count_reg - 1'b1);
                    end
                end
                REQ_INSERT:
                begin
                    if (is_full)
                        status_next = ST_FULL;
                    else if (bad_pos)
                        status_next = ST_BADPOS;
                    else
                    begin
                        walk_start = 1'b1;
                        cmd.op     = OP_OPEN;
                        cmd.at     = IDX_W'(position);
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                end
                REQ_ERASE:
                begin
                    if (is_empty)
                        status_next = ST_EMPTY;
                    else if (bad_pos)
                        status_next = ST_BADPOS;
                    else
                    begin
                        walk_start = 1'b1;
                        cmd.op     = OP_CLOSE;
                        cmd.at     = IDX_W'(position);
                        count_next = CNT_W'(count_reg - 1'b1);
                    end
                end
                REQ_FIND:
                begin
                    // empty list: miss at once
                    if (!is_empty)
                    begin
                        walk_start = 1'b1;
                        cmd.op     = OP_FIND;
                    end
                end
                default:
                begin
                    // unused code: answer ok, change nothing
                end
            endcase

            if (walk_start)
                busy_next = 1'b1;
            else
                done_next = 1'b1;
        end
        else if (busy_reg && rsp.done)
        begin
            // walker finished: count already holds the new value
            busy_next        = 1'b0;
            done_next        = 1'b1;
            status_next      = ST_OK;
            found_next       = rsp.hit ? FOUND_W'(rsp.index) : NO_INDEX;
            entry_count_next = COUNT_W'(count_reg);
        end
    end

    sle_walker u_walker
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the result beat payload
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        found_reg       <= found_next;
        entry_count_reg <= entry_count_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== verif/sequential_list_engine_core_checker.sv =====
`timescale 1ns / 1ps

module sequential_list_engine_core_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic        [sle_pkg::REQ_W-1:0]     req_type,
    input  logic        [sle_pkg::POS_W-1:0]     position,
    input  logic signed [sle_pkg::VAL_W-1:0]     value,
    input  logic                                 done,
    input  logic        [sle_pkg::STAT_W-1:0]    status,
    input  logic signed [sle_pkg::FOUND_W-1:0]   found_index,
    input  logic        [sle_pkg::COUNT_W-1:0]   entry_count,
    output int                                   mismatches,
    output int                                   outstanding
);

    import sle_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  stat;
        logic [FOUND_W-1:0] index;
        logic [COUNT_W-1:0] cnt;
    } list_answer_t;

    // Shadow copy of the list
    logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
    int                      shadow_count;

    list_answer_t pending_answers [$];

    // Shift [at, count) up one place and drop v into the gap.
    task automatic open_slot(input int at, input logic signed [VAL_W-1:0] v);
        int i;
        for (i = shadow_count; i > at; i--)
            shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[at] = v;
        shadow_count++;
    endtask

    // Shift (at, count) down one place over the entry at index at.
    task automatic close_slot(input int at);
        int i;
        for (i = at; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
        shadow_count--;
    endtask

    task automatic predict_answer(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                  input logic signed [VAL_W-1:0] key,
                                  output list_answer_t ans);
        int  i;
        bit  hit;
        ans.stat  = ST_OK;
        ans.index = NO_INDEX;
        hit       = 1'b0;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (shadow_count >= CAPACITY)
                    ans.stat = ST_FULL;
                else
                    open_slot((kind == REQ_PUSH_FRONT) ? 0 : shadow_count, key);
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (shadow_count == 0)
                    ans.stat = ST_EMPTY;
                else
                    close_slot((kind == REQ_POP_FRONT) ? 0 : shadow_count - 1);
            end
            REQ_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    ans.stat = ST_FULL;
                else if (int'(pos) >= shadow_count)
                    ans.stat = ST_BADPOS;
                else
                    open_slot(int'(pos), key);
            end
            REQ_ERASE:
            begin
                if (shadow_count == 0)
                    ans.stat = ST_EMPTY;
                else if (int'(pos) >= shadow_count)
                    ans.stat = ST_BADPOS;
                else
                    close_slot(int'(pos));
            end
            REQ_FIND:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_entries[i] == key)
                    begin
                        ans.index = i[FOUND_W-1:0];
                        hit       = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        ans.cnt = shadow_count[COUNT_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_answer_t next_ans;
        list_answer_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            pending_answers.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t ns unexpected result beat: expected none, actual status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.stat)
                    begin
                        $display("%0t ns status mismatch: expected %0d, actual %0d",
                                 $time, want.stat, status);
                        mismatches++;
                    end
                    if (found_index !== want.index)
                    begin
                        $display("%0t ns found_index mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.index), found_index);
                        mismatches++;
                    end
                    if (entry_count !== want.cnt)
                    begin
                        $display("%0t ns entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.cnt, entry_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_answer(req_type, position, value, next_ans);
                pending_answers.push_back(next_ans);
            end
            outstanding = pending_answers.size();
        end
    end

endmodule

// ===== verif/sequential_list_engine_core_tb.sv =====
`timescale 1ns / 1ps

module sequential_list_engine_core_tb;

    import sle_pkg::*;

    // Number of random beats after the directed part, and the phase split
    localparam int RANDOM_BEATS = 950;
    localparam int PHASES       = 6;

    // Request code that the block does not use
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic        [REQ_W-1:0]   req_type;
    logic        [POS_W-1:0]   position;
    logic signed [VAL_W-1:0]   value;
    logic                      done;
    logic        [STAT_W-1:0]  status;
    logic signed [FOUND_W-1:0] found_index;
    logic        [COUNT_W-1:0] entry_count;
    int                        mismatches;
    int                        outstanding;

    // Keys that recur often, so finds hit and duplicates show up
    logic signed [VAL_W-1:0] key_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
        32'sd1, 32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA
    };

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sequential_list_engine_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .entry_count (entry_count)
    );

    // Shadow list, prediction and comparison live in the checker
    sequential_list_engine_core_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .entry_count (entry_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Issue one request beat. Enter and leave at a falling edge. Hold start
    // high until a rising edge sees busy low; leave start high on return so a
    // back-to-back beat does not drop it.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] v);
        bit taken;
        start    = 1'b1;
        req_type = kind;
        position = pos;
        value    = v;
        do
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
    endtask

    // Drop start for a random stretch with the given chance per beat.
    // Long stretches let the next beat land at any point of the block's walk.
    task automatic sender_gap(input int pct);
        int n;
        if ($urandom_range(0, 99) < pct)
        begin
            n     = $urandom_range(1, 24);
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Draw one random request. Fill mode leans on pushes and inserts,
    // drain mode on pops and erases, so the count sweeps empty to full.
    task automatic random_request(input bit fill, output logic [REQ_W-1:0] kind,
                                  output logic [POS_W-1:0] pos,
                                  output logic signed [VAL_W-1:0] v);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            kind = REQ_UNUSED;
        else if (roll < 17)
            kind = REQ_FIND;
        else if (roll < 72)
        begin
            case ($urandom_range(0, 2))
                0:       kind = fill ? REQ_PUSH_BACK  : REQ_POP_BACK;
                1:       kind = fill ? REQ_PUSH_FRONT : REQ_POP_FRONT;
                default: kind = fill ? REQ_INSERT     : REQ_ERASE;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       kind = fill ? REQ_POP_BACK  : REQ_PUSH_BACK;
                1:       kind = fill ? REQ_POP_FRONT : REQ_PUSH_FRONT;
                default: kind = fill ? REQ_ERASE     : REQ_INSERT;
            endcase
        end
        if ($urandom_range(0, 1))
            pos = POS_W'($urandom_range(0, 15));
        else
            pos = POS_W'($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 60)
            v = key_pool[3'($urandom_range(0, 7))];
        else
            v = $urandom;
    endtask

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [REQ_W-1:0]        kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] v;
        int                      pct;
        int                      i;
        int                      ph;
        int                      mode_left;
        bit                      fill;

        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = '0;
        position = '0;
        value    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty list: pops and erase report empty, insert reports bad position,
        // find misses, the unused code changes nothing
        send_request(REQ_POP_FRONT, 4'd0, 32'sd0);
        send_request(REQ_POP_BACK, 4'd15, -32'sd1);
        send_request(REQ_ERASE, 4'd0, 32'sd0);
        send_request(REQ_FIND, 4'd0, 32'sd0);
        send_request(REQ_INSERT, 4'd0, 32'sd7);
        send_request(REQ_UNUSED, 4'd15, -32'sd1);

        // Extremes at both ends, an insert in the middle, hit and miss finds
        send_request(REQ_PUSH_BACK, 4'd0, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 4'd0, 32'sh8000_0000);
        send_request(REQ_INSERT, 4'd1, 32'sd0);
        send_request(REQ_FIND, 4'd0, 32'sh7FFF_FFFF);
        send_request(REQ_FIND, 4'd9, 32'sd12345);
        send_request(REQ_INSERT, 4'd15, -32'sd1);
        send_request(REQ_ERASE, 4'd15, 32'sd0);

        // Fill to capacity from both ends
        for (i = 0; i < CAPACITY - 3; i++)
            send_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 4'd0, -32'sd1 - i);

        // Full list: pushes and an insert report full ahead of the position check
        send_request(REQ_PUSH_FRONT, 4'd0, 32'sd3);
        send_request(REQ_PUSH_BACK, 4'd0, 32'sd3);
        send_request(REQ_INSERT, 4'd15, 32'sd3);
        send_request(REQ_FIND, 4'd0, -32'sd13);
        send_request(REQ_ERASE, 4'd15, 32'sd0);
        send_request(REQ_FIND, 4'd0, 32'sh7FFF_FFFF);

        // Random part: cycle sender idling over the phases
        fill      = 1'b0;
        mode_left = 0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 3)
                0:       pct = 0;
                1:       pct = 55;
                default: pct = 8;
            endcase
            for (i = 0; i < RANDOM_BEATS / PHASES; i++)
            begin
                if (mode_left == 0)
                begin
                    fill      = !fill;
                    mode_left = $urandom_range(20, 50);
                end
                mode_left--;
                random_request(fill, kind, pos, v);
                send_request(kind, pos, v);
                sender_gap(pct);
            end
        end
        start = 1'b0;

        // Drain: let every answer arrive, then watch for strays
        while (outstanding != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
